// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define GRC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/grc_pkg.sv =====
`default_nettype none
package grc_pkg;

  localparam int FRAC_BITS = 6;
  localparam int ANG_W     = 13;
  localparam int A_W       = 21;   // along-axis line coordinate, signed
  localparam int B_W       = 36;   // across-axis coordinate after divide, signed
  localparam int HC_W      = 18;   // stored hit coordinate
  localparam int M_W       = 21;   // multiplier operand
  localparam int P_W       = 42;   // multiplier product
  localparam int DIV_W     = 34;   // divider dividend / quotient
  localparam int DVS_W     = 22;   // divider divisor
  localparam int SQ_W      = 36;   // sqrt radicand
  localparam int RT_W      = 18;   // sqrt root

  localparam logic [ANG_W-1:0] TURN     = 13'd5760;
  localparam logic [ANG_W-1:0] HALF     = 13'd2880;
  localparam logic [ANG_W-1:0] QUARTER  = 13'd1440;
  localparam logic [ANG_W-1:0] Q3       = 13'd4320;
  localparam logic [ANG_W-1:0] HALF_FOV = 13'd480;
  localparam logic [ANG_W:0]   RA_OFS   = 14'd5280;
  localparam logic [21:0]      DIST_MAX = 22'd4194303;
  localparam logic [15:0]      ONE_Q14  = 16'd16384;
  localparam logic [DIV_W-1:0] HT_NUM   = 34'd20480;
  localparam logic [8:0]       HT_MAX   = 9'd320;

  localparam logic [1:0] CFG_MAP_CELLS  = 2'd0;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_WALL_SCALE = 2'd3;

  typedef struct packed {
    logic [14:0] viewer_x;
    logic [14:0] viewer_y;
    logic [12:0] view_angle;
  } req_t;

  typedef struct packed {
    logic [5:0]         ray_index;
    logic [14:0]        hit_x;
    logic [14:0]        hit_y;
    logic               hit_side;
    logic [21:0]        corrected_distance;
    logic [8:0]         wall_height;
    logic signed [15:0] wall_top;
    logic               last_ray;
  } res_t;

  // CORDIC arctangents, 1/4096 degree
  function automatic logic signed [20:0] cordic_atan(input logic [3:0] i);
    logic signed [20:0] r;
    case (i)
      4'd0:  r = 21'sd184320;
      4'd1:  r = 21'sd108810;
      4'd2:  r = 21'sd57492;
      4'd3:  r = 21'sd29184;
      4'd4:  r = 21'sd14649;
      4'd5:  r = 21'sd7331;
      4'd6:  r = 21'sd3667;
      4'd7:  r = 21'sd1833;
      4'd8:  r = 21'sd917;
      4'd9:  r = 21'sd458;
      4'd10: r = 21'sd229;
      4'd11: r = 21'sd115;
      4'd12: r = 21'sd57;
      4'd13: r = 21'sd29;
      4'd14: r = 21'sd14;
      4'd15: r = 21'sd7;
      default: r = 21'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/grc_cordic.sv =====
`default_nettype none
module grc_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [grc_pkg::ANG_W-1:0]     angle,
  output logic                               done,
  output logic signed [15:0]                 cos_q,
  output logic signed [15:0]                 sin_q
);
  import grc_pkg::*;

  logic signed [17:0] x, y, xs, ys;
  logic signed [20:0] z;
  logic [3:0]         i;
  logic               run;
  logic [1:0]         q;
  logic [1:0]         q_next;
  logic [ANG_W-1:0]   rem_next;
  logic signed [15:0] xc, yc;

  always_comb begin
    if (angle < QUARTER) begin
      q_next = 2'd0; rem_next = angle;
    end else if (angle < HALF) begin
      q_next = 2'd1; rem_next = angle - QUARTER;
    end else if (angle < Q3) begin
      q_next = 2'd2; rem_next = angle - HALF;
    end else begin
      q_next = 2'd3; rem_next = angle - Q3;
    end
    xs = x >>> i;
    ys = y >>> i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q   <= q_next;
        x   <= 18'sd9949;
        y   <= 18'sd0;
        z   <= signed'(21'({rem_next, 8'd0}));
        i   <= 4'd0;
        run <= 1'b1;
      end else if (run) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - cordic_atan(i);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + cordic_atan(i);
        end
        i <= i + 4'd1;
        if (i == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (x < 0) xc = 16'sd0;
    else if (x > 18'sd16384) xc = signed'(ONE_Q14);
    else xc = x[15:0];
    if (y < 0) yc = 16'sd0;
    else if (y > 18'sd16384) yc = signed'(ONE_Q14);
    else yc = y[15:0];
    case (q)
      2'd0: begin cos_q = xc;  sin_q = yc;  end
      2'd1: begin cos_q = -yc; sin_q = xc;  end
      2'd2: begin cos_q = -xc; sin_q = -yc; end
      default: begin cos_q = yc; sin_q = -xc; end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/grc_div.sv =====
`default_nettype none
module grc_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [grc_pkg::DIV_W-1:0]    dividend,
  input  wire logic [grc_pkg::DVS_W-1:0]    divisor,
  output logic                              done,
  output logic [grc_pkg::DIV_W-1:0]         quotient
);
  import grc_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic [5:0]       cnt;
  logic             run;

  assign shifted = {rem, quotient[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
        cnt      <= '0;
        run      <= 1'b1;
      end else if (run) begin
        // restoring, one quotient bit per cycle
        if (shifted >= {1'b0, dvs}) begin
          rem      <= DVS_W'(shifted - {1'b0, dvs});
          quotient <= {quotient[DIV_W-2:0], 1'b1};
        end else begin
          rem      <= shifted[DVS_W-1:0];
          quotient <= {quotient[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/grc_sqrt.sv =====
`default_nettype none
module grc_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [grc_pkg::SQ_W-1:0]    radicand,
  output logic                             done,
  output logic [grc_pkg::RT_W-1:0]         root
);
  import grc_pkg::*;

  localparam int REM_W = RT_W + 2;

  logic [SQ_W-1:0]    rad;
  logic [REM_W-1:0]   rem;
  logic [REM_W+1:0]   r2, trial;
  logic [4:0]         cnt;
  logic               run;

  assign r2    = {rem, rad[SQ_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        // two radicand bits in, one root bit out
        if (r2 >= trial) begin
          rem  <= REM_W'(r2 - trial);
          root <= {root[RT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(r2);
          root <= {root[RT_W-2:0], 1'b0};
        end
        rad <= {rad[SQ_W-3:0], 2'b00};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(RT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/grid_raycast_wall_columns.sv =====
`default_nettype none
`include "assert_macros.svh"
// Grid ray caster, wall columns.
// Write the map and wall scale through the cfg channel (cfg_index 0 map bits,
// 1 width, 2 height, 3 wall scale) while the block is idle; cfg_ready is always high.
// A frame request (viewer x/y, view angle) is taken when start is high and busy is
// low. The block then casts NUM_RAYS rays, left to right, and presents one result
// per ray on result with result_valid high for exactly one cycle; last_ray marks the
// final one, after which busy drops the next cycle. The receiver cannot stall.
// All work runs through one CORDIC, one restoring divider, one sqrt unit and one
// 21x21 multiplier under a sequencer, so rays are strictly one at a time.
// Per ray: ray sin/cos, then per grid step tried a multiply, divide start, divider
// run and wall check, up to 2*MAX_STEPS steps, with pass setup; a distance square
// root per pass that hits; the fisheye cosine when the ray hits; then the height
// divide (skipped for a zero distance) and emit. The divider sets the pace.
// Reset (rst, synchronous) returns the map to empty 8x8, wall scale 64, idle.
module grid_raycast_wall_columns #(
  parameter int NUM_RAYS   = 60,
  parameter int MAX_STEPS  = 8,
  parameter int TILE_SHIFT = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire grc_pkg::req_t req,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [63:0]   cfg_data,
  output logic               result_valid,
  output grc_pkg::res_t      result
);
  import grc_pkg::*;

  localparam int TS_TOTAL = FRAC_BITS + TILE_SHIFT;
  localparam int KW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam logic signed [A_W-1:0] TILE = A_W'(64'd1 << TS_TOTAL);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RAY   = 5'd1;
  localparam logic [4:0] S_TRIG  = 5'd2;
  localparam logic [4:0] S_PASS  = 5'd3;
  localparam logic [4:0] S_MUL   = 5'd4;
  localparam logic [4:0] S_DIV   = 5'd5;
  localparam logic [4:0] S_DIVW  = 5'd6;
  localparam logic [4:0] S_CHK   = 5'd7;
  localparam logic [4:0] S_DIST  = 5'd8;
  localparam logic [4:0] S_DSQ   = 5'd9;
  localparam logic [4:0] S_DSUM  = 5'd10;
  localparam logic [4:0] S_SQW   = 5'd11;
  localparam logic [4:0] S_PICK  = 5'd12;
  localparam logic [4:0] S_CCOS  = 5'd13;
  localparam logic [4:0] S_CMUL  = 5'd14;
  localparam logic [4:0] S_CD    = 5'd15;
  localparam logic [4:0] S_HDIV  = 5'd16;
  localparam logic [4:0] S_HDIVW = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  logic [63:0] map_cells;
  logic [3:0]  map_width, map_height;
  logic [7:0]  wall_scale;

  logic [4:0]  state;
  logic [5:0]  ray;
  logic [ANG_W-1:0] ra, ca;
  logic [14:0] xq, yq;
  logic signed [15:0] c_r, s_r;
  logic        p, dp;
  logic [14:0] along, across;
  logic        dir;
  logic signed [15:0] num, den;
  logic signed [A_W-1:0] line;
  logic [KW-1:0] k;
  logic        qneg;
  logic signed [B_W-1:0] bq;
  logic [1:0]  hit;
  logic [HC_W-1:0] hitx [2];
  logic [HC_W-1:0] hity [2];
  logic [RT_W-1:0] ray_dist [2];
  logic [RT_W-1:0] dsel;
  logic [SQ_W-1:0] sq0;
  logic [14:0] cc;
  logic signed [P_W-1:0] prod;
  logic signed [M_W-1:0] mul_a, mul_b;

  logic [5:0]  out_ray;
  logic [14:0] out_x, out_y;
  logic        side;
  logic [21:0] cd;
  logic [8:0]  ht;
  logic signed [15:0] top;

  // pass setup
  logic        pass_en, pass_dir;
  logic [14:0] pass_along, pass_across;
  logic signed [15:0] pass_num, pass_den;
  logic signed [A_W-1:0] base;

  // shared units
  logic cor_start, cor_done;
  logic [ANG_W-1:0] cor_angle;
  logic signed [15:0] cor_c, cor_s;
  logic div_start, div_done;
  logic [DIV_W-1:0] div_num, div_q;
  logic [DVS_W-1:0] div_den;
  logic sq_start, sq_done;
  logic [RT_W-1:0] sq_root;

  logic signed [P_W-1:0] pm;
  logic [15:0] dm;
  logic signed [B_W-1:0] qs, a_ext, px, py;
  logic        wall_hit, side_w;
  logic [ANG_W:0] ra16, ra_init;
  logic [ANG_W-1:0] view_mod;
  logic [27:0] pr_sh;
  logic signed [24:0] tt;

  function automatic logic wall_at(input logic signed [B_W-1:0] wx,
                                   input logic signed [B_W-1:0] wy);
    logic [B_W-1:0] mx, my;
    logic [3:0] w, h;
    logic [6:0] idx;
    logic r;
    w = (map_width > 4'd8) ? 4'd8 : map_width;
    h = (map_height > 4'd8) ? 4'd8 : map_height;
    mx = B_W'(wx) >> TS_TOTAL;
    my = B_W'(wy) >> TS_TOTAL;
    idx = 7'(my[2:0]) * 7'(w) + 7'(mx[2:0]);
    r = 1'b0;
    if (!wx[B_W-1] && !wy[B_W-1] && mx < B_W'(w) && my < B_W'(h))
      r = map_cells[idx[5:0]];
    return r;
  endfunction

  grc_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .angle(cor_angle),
    .done(cor_done), .cos_q(cor_c), .sin_q(cor_s)
  );

  grc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_q)
  );

  grc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq0 + SQ_W'(prod)),
    .done(sq_done), .root(sq_root)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (!p) begin
      pass_en     = (ra != '0) && (ra != HALF) && (s_r != 16'sd0);
      pass_along  = yq;
      pass_across = xq;
      pass_dir    = (ra < HALF);
      pass_num    = c_r;
      pass_den    = s_r;
    end else begin
      pass_en     = (ra != QUARTER) && (ra != Q3) && (c_r != 16'sd0);
      pass_along  = xq;
      pass_across = yq;
      pass_dir    = (ra < QUARTER) || (ra > Q3);
      pass_num    = s_r;
      pass_den    = c_r;
    end
    base = (A_W'({1'b0, pass_along}) >>> TS_TOTAL) <<< TS_TOTAL;

    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        mul_a = line - A_W'({1'b0, along});
        mul_b = M_W'(num);
      end
      S_DIST: begin
        mul_a = M_W'({1'b0, hitx[dp]}) - M_W'({1'b0, xq});
        mul_b = mul_a;
      end
      S_DSQ: begin
        mul_a = M_W'({1'b0, hity[dp]}) - M_W'({1'b0, yq});
        mul_b = mul_a;
      end
      S_CMUL: begin
        mul_a = M_W'({1'b0, dsel});
        mul_b = M_W'({1'b0, cc});
      end
      default: ;
    endcase

    pm = prod[P_W-1] ? -prod : prod;
    dm = den[15] ? 16'(-den) : 16'(den);
    cor_start = (state == S_RAY) || (state == S_PICK && hit != 2'b00);
    cor_angle = (state == S_PICK) ? ca : ra;
    div_start = (state == S_DIV) || (state == S_HDIV && cd != '0);
    div_num   = (state == S_DIV) ? DIV_W'(pm[DIV_W-1:0]) : DIV_W'(wall_scale) * HT_NUM;
    div_den   = (state == S_DIV) ? DVS_W'(dm) : DVS_W'(cd);
    sq_start  = (state == S_DSUM);

    qs    = qneg ? -B_W'(div_q) : B_W'(div_q);
    a_ext = B_W'(line);
    px    = p ? a_ext : bq;
    py    = p ? bq : a_ext;
    wall_hit = wall_at(px, py);
    side_w   = hit[1] && (!hit[0] || ray_dist[1] < ray_dist[0]);

    view_mod = (req.view_angle >= TURN) ? req.view_angle - TURN : req.view_angle;
    ra_init  = {1'b0, view_mod} + RA_OFS;
    ra16     = {1'b0, ra} + 14'd16;
    pr_sh    = 28'(prod[P_W-1:14]);
    tt       = 25'sd160 - signed'(25'(div_q[DIV_W-1:1]));
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_cells  <= '0;
      map_width  <= 4'd8;
      map_height <= 4'd8;
      wall_scale <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_CELLS:  map_cells  <= cfg_data;
        CFG_MAP_WIDTH:  map_width  <= cfg_data[3:0];
        CFG_MAP_HEIGHT: map_height <= cfg_data[3:0];
        CFG_WALL_SCALE: wall_scale <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hit   <= 2'b00;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            xq    <= req.viewer_x;
            yq    <= req.viewer_y;
            ra    <= (ra_init >= {1'b0, TURN}) ? ANG_W'(ra_init - {1'b0, TURN})
                                               : ANG_W'(ra_init);
            ca    <= HALF_FOV;
            ray   <= '0;
            state <= S_RAY;
          end
        end
        S_RAY: begin
          hit   <= 2'b00;
          state <= S_TRIG;
        end
        S_TRIG: begin
          if (cor_done) begin
            c_r   <= cor_c;
            s_r   <= cor_s;
            p     <= 1'b0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          if (pass_en) begin
            along  <= pass_along;
            across <= pass_across;
            dir    <= pass_dir;
            num    <= pass_num;
            den    <= pass_den;
            line   <= pass_dir ? base + TILE : base - A_W'(1);
            k      <= '0;
            state  <= S_MUL;
          end else if (!p) begin
            p <= 1'b1;
          end else begin
            dp    <= 1'b0;
            state <= S_DIST;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: begin
          qneg  <= prod[P_W-1] ^ den[15];
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            bq    <= B_W'(signed'({1'b0, across})) + qs;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (wall_hit || k == KW'(MAX_STEPS - 1)) begin
            if (wall_hit) begin
              hit[p]  <= 1'b1;
              hitx[p] <= px[HC_W-1:0];
              hity[p] <= py[HC_W-1:0];
            end
            if (!p) begin
              p     <= 1'b1;
              state <= S_PASS;
            end else begin
              dp    <= 1'b0;
              state <= S_DIST;
            end
          end else begin
            k     <= k + KW'(1);
            line  <= dir ? line + TILE : line - TILE;
            state <= S_MUL;
          end
        end
        S_DIST: begin
          if (hit[dp]) begin
            state <= S_DSQ;
          end else if (!dp) begin
            dp <= 1'b1;
          end else begin
            state <= S_PICK;
          end
        end
        S_DSQ: begin
          sq0   <= SQ_W'(prod);
          state <= S_DSUM;
        end
        S_DSUM: state <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            ray_dist[dp] <= sq_root;
            if (dp) begin
              state <= S_PICK;
            end else begin
              dp    <= 1'b1;
              state <= S_DIST;
            end
          end
        end
        S_PICK: begin
          side <= side_w;
          dsel <= side_w ? ray_dist[1] : ray_dist[0];
          if (hit == 2'b00) begin
            out_x <= xq;
            out_y <= yq;
            cd    <= DIST_MAX;
            state <= S_HDIV;
          end else begin
            out_x <= (hitx[side_w] > HC_W'(32767)) ? 15'd32767 : hitx[side_w][14:0];
            out_y <= (hity[side_w] > HC_W'(32767)) ? 15'd32767 : hity[side_w][14:0];
            state <= S_CCOS;
          end
        end
        S_CCOS: begin
          if (cor_done) begin
            cc    <= (cor_c < 0) ? 15'd0 : cor_c[14:0];
            state <= S_CMUL;
          end
        end
        S_CMUL: state <= S_CD;
        S_CD: begin
          cd    <= (pr_sh > 28'(DIST_MAX)) ? DIST_MAX : pr_sh[21:0];
          state <= S_HDIV;
        end
        S_HDIV: begin
          if (cd == '0) begin
            ht    <= HT_MAX;
            top   <= -16'sd32768;
            state <= S_EMIT;
          end else begin
            state <= S_HDIVW;
          end
        end
        S_HDIVW: begin
          if (div_done) begin
            ht    <= (div_q > DIV_W'(HT_MAX)) ? HT_MAX : div_q[8:0];
            top   <= (tt < -25'sd32768) ? -16'sd32768 : tt[15:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (ray == 6'(NUM_RAYS - 1)) begin
            state <= S_IDLE;
          end else begin
            ray   <= ray + 6'd1;
            ra    <= (ra16 >= {1'b0, TURN}) ? ANG_W'(ra16 - {1'b0, TURN}) : ANG_W'(ra16);
            ca    <= (ca < 13'd16) ? ca + TURN - 13'd16 : ca - 13'd16;
            state <= S_RAY;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ray      = ray;
  assign result_valid = (state == S_EMIT);
  assign result.ray_index          = out_ray;
  assign result.hit_x              = out_x;
  assign result.hit_y              = out_y;
  assign result.hit_side           = side;
  assign result.corrected_distance = cd;
  assign result.wall_height        = ht;
  assign result.wall_top           = top;
  assign result.last_ray           = (ray == 6'(NUM_RAYS - 1));

  `GRC_ASSERT(a_result_in_frame, result_valid |-> busy, "result outside a frame")
  `GRC_ASSERT(a_last_ends, (result_valid && result.last_ray) |=> !busy,
              "frame did not end after last ray")
  `GRC_ASSERT(a_start_takes, (start && !busy) |=> busy, "request not taken")
  `GRC_NEVER(a_height_clamp, result_valid && result.wall_height > 9'd320,
             "wall height above clamp")

endmodule
`default_nettype wire

// ===== test/grid_raycast_wall_columns_test.sv =====
`timescale 1ns / 1ps
module grid_raycast_wall_columns_test;
  import grc_pkg::*;

  localparam int NUM_RAYS = 60;
  localparam int MAX_STEPS = 8;
  localparam int TILE_SHIFT = 6;
  localparam int CELL_SH = 6 + TILE_SHIFT;
  localparam int ANG_TURN = 5760;
  localparam int ANG_QTR = 1440;
  localparam int FOV_HALF = 480;

  typedef enum logic [1:0] {OP_FRAME, OP_CFG, OP_SYNC} op_kind_e;
  typedef struct {
    op_kind_e    kind;
    req_t        frame;
    logic [1:0]  idx;
    logic [63:0] data;
  } op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_MAP_CELLS;
  logic [63:0] cfg_data = '0;
  logic result_valid;
  res_t result;

  grid_raycast_wall_columns #(
    .NUM_RAYS(NUM_RAYS), .MAX_STEPS(MAX_STEPS), .TILE_SHIFT(TILE_SHIFT)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  op_t  pend_ops[$];
  res_t expected_columns[$];
  int   err_cnt = 0;
  int   frames_left = 0;
  int   gap = 0;

  // shadow of the block's registers
  logic [63:0] wall_map = '0;
  logic [3:0]  map_w = 4'd8;
  logic [3:0]  map_h = 4'd8;
  logic [7:0]  wscale = 8'd64;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_q14(longint v);
    if (v < 0) return 0;
    if (v > 16384) return 16384;
    return v;
  endfunction

  function automatic void trig(input int unsigned ang, output longint c, output longint s);
    longint atan_tbl[16] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
                             917, 458, 229, 115, 57, 29, 14, 7};
    longint x, y, z, nx;
    int unsigned q, rem;
    x = 9949;
    y = 0;
    ang = ang % ANG_TURN;
    q = ang / ANG_QTR;
    rem = ang % ANG_QTR;
    z = longint'(rem) * 256;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        z -= atan_tbl[i];
      end else begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        z += atan_tbl[i];
      end
      x = nx;
    end
    x = clamp_q14(x);
    y = clamp_q14(y);
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic bit cell_solid(longint px, longint py);
    longint unsigned w, h, mx, my;
    w = (map_w > 8) ? 8 : map_w;
    h = (map_h > 8) ? 8 : map_h;
    if (px < 0 || py < 0) return 0;
    mx = longint'(px) >> CELL_SH;
    my = longint'(py) >> CELL_SH;
    if (mx >= w || my >= h) return 0;
    return wall_map[my * w + mx];
  endfunction

  function automatic bit trace_lines(input longint along0, input longint across0,
                                     input int dir, input longint num, input longint den,
                                     input bit horiz, inout longint hx, inout longint hy);
    longint tile, line, a, b;
    tile = longint'(1) << CELL_SH;
    line = (along0 >>> CELL_SH) <<< CELL_SH;
    if (den == 0) return 0;
    line = (dir > 0) ? line + tile : line - 1;
    for (int k = 0; k < MAX_STEPS; k++) begin
      a = line + ((dir > 0) ? tile : -tile) * k;
      b = across0 + (a - along0) * num / den;
      if (horiz ? cell_solid(b, a) : cell_solid(a, b)) begin
        hx = horiz ? b : a;
        hy = horiz ? a : b;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned span(longint px, longint py, longint x0, longint y0);
    longint dx, dy;
    dx = px - x0;
    dy = py - y0;
    return int_sqrt(longint'(unsigned'(dx * dx)) + longint'(unsigned'(dy * dy)));
  endfunction

  function automatic logic [14:0] sat_coord(longint v);
    if (v < 0) return 15'd0;
    if (v > 32767) return 15'd32767;
    return v[14:0];
  endfunction

  task automatic cast_frame(input req_t fr);
    longint xq, yq, c, s, cc, cs, hx, hy, vx, vy, px, py, top, ht, hraw;
    longint unsigned dh, dv, d, cd;
    int unsigned view, ra;
    bit hhit, vhit, side;
    res_t col;
    xq = fr.viewer_x;
    yq = fr.viewer_y;
    view = fr.view_angle % ANG_TURN;
    for (int r = 0; r < NUM_RAYS; r++) begin
      ra = (view + ANG_TURN - FOV_HALF + 16 * r) % ANG_TURN;
      hx = xq; hy = yq; vx = xq; vy = yq;
      hhit = 0; vhit = 0; dh = 0; dv = 0;
      trig(ra, c, s);
      if (ra != 0 && ra != ANG_TURN / 2)
        hhit = trace_lines(yq, xq, (ra < ANG_TURN / 2) ? 1 : -1, c, s, 1, hx, hy);
      if (ra != ANG_QTR && ra != 3 * ANG_QTR)
        vhit = trace_lines(xq, yq, (ra < ANG_QTR || ra > 3 * ANG_QTR) ? 1 : -1,
                           s, c, 0, vx, vy);
      if (hhit) dh = span(hx, hy, xq, yq);
      if (vhit) dv = span(vx, vy, xq, yq);
      side = vhit && (!hhit || dv < dh);
      if (!hhit && !vhit) begin
        px = xq; py = yq;
        cd = 4194303;
      end else begin
        d = side ? dv : dh;
        px = side ? vx : hx;
        py = side ? vy : hy;
        trig((ANG_TURN + FOV_HALF - 16 * r) % ANG_TURN, cc, cs);
        if (cc < 0) cc = 0;
        cd = (d * longint'(unsigned'(cc))) >> 14;
        if (cd > 4194303) cd = 4194303;
      end
      if (cd == 0) begin
        ht = 320;
        top = -32768;
      end else begin
        hraw = longint'((longint'(unsigned'(wscale)) * 20480) / cd);
        top = 160 - (hraw >>> 1);
        if (top < -32768) top = -32768;
        ht = (hraw > 320) ? 320 : hraw;
      end
      col.ray_index = r[5:0];
      col.hit_x = sat_coord(px);
      col.hit_y = sat_coord(py);
      col.hit_side = side;
      col.corrected_distance = cd[21:0];
      col.wall_height = ht[8:0];
      col.wall_top = top[15:0];
      col.last_ray = (r == NUM_RAYS - 1);
      expected_columns.push_back(col);
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic nxt_start, nxt_cv;
    op_t op;
    nxt_start = start;
    nxt_cv = cfg_valid;
    if (!rst) begin
      if (start && !busy) begin
        cast_frame(req);
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAP_CELLS:  wall_map = cfg_data;
          CFG_MAP_WIDTH:  map_w = cfg_data[3:0];
          CFG_MAP_HEIGHT: map_h = cfg_data[3:0];
          CFG_WALL_SCALE: wscale = cfg_data[7:0];
          default: ;
        endcase
        nxt_cv = 1'b0;
      end
      if (!nxt_start && !nxt_cv) begin
        if (gap > 0) begin
          gap--;
        end else if (pend_ops.size() > 0) begin
          op = pend_ops[0];
          case (op.kind)
            OP_FRAME: begin
              void'(pend_ops.pop_front());
              nxt_start = 1'b1;
              req <= op.frame;
              frames_left--;
            end
            OP_CFG: begin
              if (expected_columns.size() == 0 && !busy && !start) begin
                void'(pend_ops.pop_front());
                nxt_cv = 1'b1;
                cfg_index <= op.idx;
                cfg_data <= op.data;
              end
            end
            default: begin
              // hold off until every column of earlier frames is out
              if (expected_columns.size() == 0) void'(pend_ops.pop_front());
            end
          endcase
          if (frames_left > 15 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        end
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cv;
  end

  task automatic chk(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      err_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && result_valid) begin
      if (expected_columns.size() == 0) begin
        $error("unexpected column, ray_index %0d", result.ray_index);
        err_cnt++;
      end else begin
        e = expected_columns.pop_front();
        chk("ray_index", e.ray_index, result.ray_index);
        chk("hit_x", e.hit_x, result.hit_x);
        chk("hit_y", e.hit_y, result.hit_y);
        chk("hit_side", e.hit_side, result.hit_side);
        chk("corrected_distance", e.corrected_distance, result.corrected_distance);
        chk("wall_height", e.wall_height, result.wall_height);
        chk("wall_top", e.wall_top, result.wall_top);
        chk("last_ray", e.last_ray, result.last_ray);
      end
    end
  end

  task automatic add_frame(input int x, input int y, input int ang);
    op_t op;
    op.kind = OP_FRAME;
    op.frame.viewer_x = x[14:0];
    op.frame.viewer_y = y[14:0];
    op.frame.view_angle = ang[12:0];
    op.idx = CFG_MAP_CELLS;
    op.data = '0;
    pend_ops.push_back(op);
    frames_left++;
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [63:0] data);
    op_t op;
    op.kind = OP_CFG;
    op.frame = '0;
    op.idx = idx;
    op.data = data;
    pend_ops.push_back(op);
  endtask

  task automatic add_sync();
    op_t op;
    op.kind = OP_SYNC;
    op.frame = '0;
    op.idx = CFG_MAP_CELLS;
    op.data = '0;
    pend_ops.push_back(op);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) * 4096;            // on a tile line
      1: return $urandom_range(0, 7) * 4096 + $urandom_range(0, 1) * 4095;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 511) * 16;             // rays can land on exact axes
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  initial begin
    // directed: border walls, edges of the fields, axis angles, wrap
    add_cfg(CFG_MAP_CELLS, 64'hFF81_8181_8181_81FF);
    add_cfg(CFG_MAP_WIDTH, 64'd8);
    add_cfg(CFG_MAP_HEIGHT, 64'd8);
    add_cfg(CFG_WALL_SCALE, 64'd64);
    add_frame(16384, 16384, 0);
    add_frame(16384, 16384, 480);
    add_frame(16384, 16384, 1440 + 480);
    add_frame(16384, 16384, 5759);
    add_frame(16384, 16384, 8191);
    add_frame(16384, 16384, 5760 + 480);
    add_frame(0, 0, 720);
    add_frame(32767, 32767, 3600);
    add_frame(8192, 20000, 2880);
    add_frame(4096, 4096, 2880);
    add_frame(4096, 8000, 2880 + 480);
    add_frame(12000, 4096, 4320);
    add_sync();
    add_frame(5000, 5000, 4320 + 480);
    add_cfg(CFG_MAP_CELLS, 64'h0000_0000_0000_0001);
    add_cfg(CFG_MAP_WIDTH, 64'd15);
    add_cfg(CFG_MAP_HEIGHT, 64'd0);
    add_cfg(CFG_WALL_SCALE, 64'd255);
    add_frame(3000, 3000, 3600);
    add_cfg(CFG_MAP_HEIGHT, 64'd1);
    add_cfg(CFG_MAP_WIDTH, 64'd1);
    add_frame(3000, 3000, 3600);
    add_frame(100, 100, 3600);
    add_cfg(CFG_MAP_CELLS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(CFG_MAP_WIDTH, 64'd8);
    add_cfg(CFG_MAP_HEIGHT, 64'd15);
    add_cfg(CFG_WALL_SCALE, 64'd0);
    add_frame(20000, 12000, 1000);
    add_cfg(CFG_WALL_SCALE, 64'd1);
    add_frame(4096, 4096, 2000);
    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      add_cfg(CFG_MAP_CELLS, {$urandom, $urandom} | {$urandom, $urandom});
      add_cfg(CFG_MAP_WIDTH, (ph == 0) ? 64'd0 : 64'($urandom_range(1, 15)));
      add_cfg(CFG_MAP_HEIGHT, 64'($urandom_range(0, 15)));
      add_cfg(CFG_WALL_SCALE, 64'($urandom_range(0, 255)));
      for (int n = 0; n < 20; n++) begin
        add_frame(rand_coord(), rand_coord(), rand_angle());
        if (ph == 2 && n == 10) add_sync();
      end
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pend_ops.size() == 0 && !start && !cfg_valid);
    wait (expected_columns.size() == 0);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && expected_columns.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
